/* rtl/aou_pkg.sv */
// ---------------------------------------------------------------------------
// aou_pkg
// Types and constants shared by the Adam optimizer update unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aou_pkg;

  localparam int IDX_W       = 17;
  localparam int NUM_WEIGHTS = 131072;
  localparam int ADDR_W      = $clog2(NUM_WEIGHTS);
  localparam int CMP_W       = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int SR_W      = 24;
  localparam int CORR_W    = 32;

  localparam int V_W      = 48;
  localparam int MHAT_W   = 44;
  localparam int VSC_W    = 80;
  localparam int NUM_W    = 76;
  localparam int ROOT_W   = 40;
  localparam int DEN_W    = 41;
  localparam int QUO_W    = 40;

  localparam int FRONT_LAT  = 7;
  localparam int SQRT_STEPS = VSC_W / 2;
  localparam int DIV_STEPS  = NUM_W;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int TAG_DEPTH  = 1 + FRONT_LAT + SQRT_STEPS + DIV_LAT;

  localparam logic signed [31:0] B1_Q30 = 32'sd966367642;
  localparam logic signed [31:0] C1_Q30 = 32'sd107374182;
  localparam logic [31:0]        B2_Q32 = 32'd4290672329;
  localparam logic [22:0]        C2_Q32 = 23'd4294967;
  localparam logic [DEN_W-1:0]   EPS_Q32 = DEN_W'(43);
  localparam logic [V_W-1:0]     V_MAX  = '1;

  localparam logic [SR_W-1:0]   STEP_RATE_RST   = SR_W'(3355);
  localparam logic [CORR_W-1:0] FIRST_CORR_RST  = CORR_W'(10485760);
  localparam logic [CORR_W-1:0] SECOND_CORR_RST = CORR_W'(1048576000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_RATE   = 2'd0,
    CFG_FIRST_CORR  = 2'd1,
    CFG_SECOND_CORR = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   weight_index;
    logic signed [31:0] gradient;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   updated_index;
    logic signed [31:0] new_weight;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic               inrange;
    logic               sat;
    logic signed [31:0] m;
    logic [V_W-1:0]     v;
    logic signed [31:0] w0;
  } side_t;

endpackage

`default_nettype wire

/* rtl/adam_optimizer_update_unit.sv */
// ---------------------------------------------------------------------------
// adam_optimizer_update_unit
// Per-weight Adam step over on-chip weight and moment stores.
//
// Input beats (in_valid/in_stall/in_data) carry a weight index and its summed
// gradient; each gives one output beat (out_valid/out_stall/out_data) with
// the new weight. One beat per cycle is taken while in_stall is low; the
// result passes the read stage, the front end, the 40-stage square root and
// the 78-stage divider. A beat whose index matches an in-range one still in
// flight is held off until that one has written back.
// After reset the stores are cleared one entry per cycle, all NUM_WEIGHTS
// (131072) entries; in_stall stays high meanwhile. An output stall while
// out_valid is high freezes the whole pipeline and raises in_stall.
// The cfg port writes step rate and both bias-correction reciprocals; write
// only while no beat is in flight.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adam_optimizer_update_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  aou_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output aou_pkg::out_item_t               out_data,
  input  wire                              cfg_wr_en,
  input  wire [aou_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [aou_pkg::CFG_W-1:0]         cfg_data
);
  import aou_pkg::*;

  logic [SR_W-1:0]   step_rate_r;
  logic [CORR_W-1:0] first_corr_r, second_corr_r;

  logic              en, acc, hazard, in_range;
  logic [ADDR_W-1:0] rd_addr;

  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic signed [31:0] w_mem [0:NUM_WEIGHTS-1];
  logic signed [31:0] m_mem [0:NUM_WEIGHTS-1];
  logic [V_W-1:0]     v_mem [0:NUM_WEIGHTS-1];

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic signed [31:0] mem_wd_w, mem_wd_m;
  logic [V_W-1:0]    mem_wd_v;

  // read stage
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_inrange_r;
  logic signed [31:0] rd_g_r, rd_w_r, rd_m_r;
  logic [V_W-1:0]     rd_v_r;
  side_t              rd_side;

  logic              tag_vld_r [0:TAG_DEPTH-1];
  logic [IDX_W-1:0]  tag_idx_r [0:TAG_DEPTH-1];

  logic              fr_vld, sq_vld, dv_vld;
  side_t             fr_side, sq_side, dv_side;
  logic [VSC_W-1:0]  fr_vsc;
  logic [NUM_W-1:0]  fr_num, sq_num;
  logic [ROOT_W-1:0] sq_root;
  logic [QUO_W:0]    dv_quo;

  logic signed [QUO_W+1:0] wx, qx;
  logic signed [31:0]      w_new;
  logic                    w_sat;

  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_rate_r   <= STEP_RATE_RST;
      first_corr_r  <= FIRST_CORR_RST;
      second_corr_r <= SECOND_CORR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_STEP_RATE:   step_rate_r   <= cfg_data[SR_W-1:0];
        CFG_FIRST_CORR:  first_corr_r  <= cfg_data[CORR_W-1:0];
        CFG_SECOND_CORR: second_corr_r <= cfg_data[CORR_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(NUM_WEIGHTS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // handshake and hazard
  assign en       = !out_valid_r || !out_stall;
  assign in_range = (CMP_W'(in_data.weight_index) < CMP_W'(NUM_WEIGHTS));
  assign rd_addr  = ADDR_W'(in_data.weight_index);

  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < TAG_DEPTH; i++) begin
      if (tag_vld_r[i] && (tag_idx_r[i] == in_data.weight_index)) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_stall = !en || clr_busy_r || hazard;
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAG_DEPTH; i++) begin
        tag_vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      tag_vld_r[0] <= acc && in_range;
      for (int i = 1; i < TAG_DEPTH; i++) begin
        tag_vld_r[i] <= tag_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_idx_r[0] <= in_data.weight_index;
      for (int i = 1; i < TAG_DEPTH; i++) begin
        tag_idx_r[i] <= tag_idx_r[i-1];
      end
    end
  end

  // stores
  always_comb begin
    if (clr_busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wd_w  = '0;
      mem_wd_m  = '0;
      mem_wd_v  = '0;
    end else begin
      mem_we    = en && dv_vld && dv_side.inrange;
      mem_waddr = ADDR_W'(dv_side.idx);
      mem_wd_w  = w_new;
      mem_wd_m  = dv_side.m;
      mem_wd_v  = dv_side.v;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      w_mem[mem_waddr] <= mem_wd_w;
      m_mem[mem_waddr] <= mem_wd_m;
      v_mem[mem_waddr] <= mem_wd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_w_r       <= w_mem[rd_addr];
      rd_m_r       <= m_mem[rd_addr];
      rd_v_r       <= v_mem[rd_addr];
      rd_idx_r     <= in_data.weight_index;
      rd_inrange_r <= in_range;
      rd_g_r       <= in_data.gradient;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (en) begin
      rd_vld_r <= acc;
    end
  end

  always_comb begin
    rd_side         = '0;
    rd_side.idx     = rd_idx_r;
    rd_side.inrange = rd_inrange_r;
    rd_side.m       = rd_m_r;
    rd_side.v       = rd_v_r;
    rd_side.w0      = rd_w_r;
  end

  aou_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (rd_vld_r),
    .in_side     (rd_side),
    .in_g        (rd_g_r),
    .step_rate   (step_rate_r),
    .first_corr  (first_corr_r),
    .second_corr (second_corr_r),
    .out_vld     (fr_vld),
    .out_side    (fr_side),
    .out_vsc     (fr_vsc),
    .out_num     (fr_num)
  );

  aou_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .in_side  (fr_side),
    .in_rad   (fr_vsc),
    .in_num   (fr_num),
    .out_vld  (sq_vld),
    .out_side (sq_side),
    .out_root (sq_root),
    .out_num  (sq_num)
  );

  aou_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sq_vld),
    .in_side  (sq_side),
    .in_root  (sq_root),
    .in_num   (sq_num),
    .out_vld  (dv_vld),
    .out_side (dv_side),
    .out_quo  (dv_quo)
  );

  // weight update and output beat
  always_comb begin
    qx = $signed({1'b0, dv_quo});
    wx = (QUO_W+2)'(dv_side.w0) + (dv_side.m[31] ? qx : -qx);
    w_sat = 1'b0;
    if (wx > (QUO_W+2)'(32'sh7fffffff)) begin
      w_new = 32'sh7fffffff;
      w_sat = 1'b1;
    end else if (wx < (QUO_W+2)'(32'sh80000000)) begin
      w_new = 32'sh80000000;
      w_sat = 1'b1;
    end else begin
      w_new = wx[31:0];
    end
    out_data_nxt.updated_index = dv_side.idx;
    if (dv_side.inrange) begin
      out_data_nxt.new_weight = w_new;
      out_data_nxt.saturated  = dv_side.sat | w_sat;
    end else begin
      out_data_nxt.new_weight = '0;
      out_data_nxt.saturated  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/aou_front.sv */
// ---------------------------------------------------------------------------
// aou_front
// Moment update, bias correction products and step numerator, 7 stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aou_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire                          in_vld,
  input  aou_pkg::side_t               in_side,
  input  wire signed [31:0]            in_g,
  input  wire [aou_pkg::SR_W-1:0]      step_rate,
  input  wire [aou_pkg::CORR_W-1:0]    first_corr,
  input  wire [aou_pkg::CORR_W-1:0]    second_corr,
  output logic                         out_vld,
  output aou_pkg::side_t               out_side,
  output logic [aou_pkg::VSC_W-1:0]    out_vsc,
  output logic [aou_pkg::NUM_W-1:0]    out_num
);
  import aou_pkg::*;

  logic [FRONT_LAT-1:0] vld_r;

  // F1
  side_t              s1_r;
  logic signed [62:0] pm_r, pm_nxt, pg_r, pg_nxt;
  logic [63:0]        pa_r, pa_nxt, g2_r, g2_nxt;
  logic [51:0]        pb_r, pb_nxt;
  logic signed [63:0] g64;
  // F2
  side_t              s2_r, s2_nxt;
  logic [52:0]        vb_r, vb_nxt;
  logic [54:0]        pc_r, pc_nxt, pd_r, pd_nxt;
  logic signed [63:0] msum;
  logic signed [33:0] mfull;
  // F3
  side_t              s3_r, s3_nxt;
  logic [31:0]        mabs_r, mabs_nxt;
  logic [55:0]        vg, vsum;
  logic [51:0]        vsh;
  // F4
  side_t              s4_r;
  logic [63:0]        pmc_r, pvlo_r;
  logic [47:0]        pvhi_r;
  // F5
  side_t              s5_r;
  logic [MHAT_W-1:0]  mhat_r;
  logic [VSC_W-1:0]   vsc5_r;
  // F6
  side_t              s6_r;
  logic [55:0]        pnlo_r;
  logic [35:0]        pnhi_r;
  logic [VSC_W-1:0]   vsc6_r;
  // F7
  side_t              s7_r;
  logic [VSC_W-1:0]   vsc7_r;
  logic [NUM_W-1:0]   num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[FRONT_LAT-2:0], in_vld};
    end
  end

  assign g64    = 64'(in_g);
  assign pm_nxt = 63'(in_side.m) * 63'(B1_Q30);
  assign pg_nxt = 63'(in_g) * 63'(C1_Q30);
  assign pa_nxt = 64'(B2_Q32) * 64'({in_side.v[27:0], 4'b0000});
  assign pb_nxt = 52'(B2_Q32) * 52'(in_side.v[47:28]);
  assign g2_nxt = 64'(g64 * g64);

  always_comb begin
    msum   = 64'(pm_r) + 64'(pg_r) + 64'sd536870912;
    mfull  = msum[63:30];
    s2_nxt = s1_r;
    s2_nxt.sat = 1'b0;
    if (mfull > 34'sd2147483647) begin
      s2_nxt.m   = 32'sh7fffffff;
      s2_nxt.sat = 1'b1;
    end else if (mfull < -34'sd2147483648) begin
      s2_nxt.m   = 32'sh80000000;
      s2_nxt.sat = 1'b1;
    end else begin
      s2_nxt.m = mfull[31:0];
    end
    vb_nxt = 53'(pb_r) + 53'(pa_r[63:32]) + 53'(pa_r[31]);
    pc_nxt = 55'(C2_Q32) * 55'(g2_r[31:0]);
    pd_nxt = 55'(C2_Q32) * 55'(g2_r[62:32]);
  end

  always_comb begin
    vg     = 56'(pd_r) + 56'(pc_r[54:32]) + 56'(pc_r[31]);
    vsum   = 56'(vb_r) + vg + 56'd8;
    vsh    = vsum[55:4];
    s3_nxt = s2_r;
    if (|vsh[51:48]) begin
      s3_nxt.v   = V_MAX;
      s3_nxt.sat = 1'b1;
    end else begin
      s3_nxt.v = vsh[47:0];
    end
    mabs_nxt = s2_r.m[31] ? (~s2_r.m + 32'd1) : s2_r.m;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r   <= in_side;
      pm_r   <= pm_nxt;
      pg_r   <= pg_nxt;
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      g2_r   <= g2_nxt;

      s2_r   <= s2_nxt;
      vb_r   <= vb_nxt;
      pc_r   <= pc_nxt;
      pd_r   <= pd_nxt;

      s3_r   <= s3_nxt;
      mabs_r <= mabs_nxt;

      s4_r   <= s3_r;
      pmc_r  <= 64'(mabs_r) * 64'(first_corr);
      pvlo_r <= 64'(s3_r.v[31:0]) * 64'(second_corr);
      pvhi_r <= 48'(s3_r.v[47:32]) * 48'(second_corr);

      s5_r   <= s4_r;
      mhat_r <= MHAT_W'((pmc_r + 64'd524288) >> 20);
      vsc5_r <= {pvhi_r, 32'b0} + VSC_W'(pvlo_r);

      s6_r   <= s5_r;
      pnlo_r <= 56'(mhat_r[31:0]) * 56'(step_rate);
      pnhi_r <= 36'(mhat_r[MHAT_W-1:32]) * 36'(step_rate);
      vsc6_r <= vsc5_r;

      s7_r   <= s6_r;
      vsc7_r <= vsc6_r;
      num_r  <= {({pnhi_r, 32'b0} + 68'(pnlo_r)), 8'b0};
    end
  end

  assign out_vld  = vld_r[FRONT_LAT-1];
  assign out_side = s7_r;
  assign out_vsc  = vsc7_r;
  assign out_num  = num_r;

endmodule

`default_nettype wire

/* rtl/aou_sqrt.sv */
// ---------------------------------------------------------------------------
// aou_sqrt
// Pipelined integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aou_sqrt (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire                          in_vld,
  input  aou_pkg::side_t               in_side,
  input  wire [aou_pkg::VSC_W-1:0]     in_rad,
  input  wire [aou_pkg::NUM_W-1:0]     in_num,
  output logic                         out_vld,
  output aou_pkg::side_t               out_side,
  output logic [aou_pkg::ROOT_W-1:0]   out_root,
  output logic [aou_pkg::NUM_W-1:0]    out_num
);
  import aou_pkg::*;

  logic                vld_r  [0:SQRT_STEPS-1];
  logic [ROOT_W+2:0]   rem_r  [0:SQRT_STEPS-1];
  logic [ROOT_W-1:0]   root_r [0:SQRT_STEPS-1];
  logic [VSC_W-1:0]    rad_r  [0:SQRT_STEPS-1];
  side_t               side_r [0:SQRT_STEPS-1];
  logic [NUM_W-1:0]    num_r  [0:SQRT_STEPS-1];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    logic              v_in;
    logic [ROOT_W+2:0] rem_in, cur, test;
    logic [ROOT_W-1:0] root_in;
    logic [VSC_W-1:0]  rad_in;
    side_t             side_in;
    logic [NUM_W-1:0]  num_in;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
      assign num_in  = in_num;
    end else begin : g_next
      assign v_in    = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign side_in = side_r[i-1];
      assign num_in  = num_r[i-1];
    end

    assign cur  = {rem_in[ROOT_W:0], rad_in[VSC_W-1:VSC_W-2]};
    assign test = {1'b0, root_in, 2'b01};
    assign ge   = (cur >= test);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? (cur - test) : cur;
        root_r[i] <= {root_in[ROOT_W-2:0], ge};
        rad_r[i]  <= {rad_in[VSC_W-3:0], 2'b00};
        side_r[i] <= side_in;
        num_r[i]  <= num_in;
      end
    end
  end

  assign out_vld  = vld_r[SQRT_STEPS-1];
  assign out_side = side_r[SQRT_STEPS-1];
  assign out_root = root_r[SQRT_STEPS-1];
  assign out_num  = num_r[SQRT_STEPS-1];

endmodule

`default_nettype wire

/* rtl/aou_div.sv */
// ---------------------------------------------------------------------------
// aou_div
// Pipelined restoring divider with round half up and quotient cap.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aou_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire                          in_vld,
  input  aou_pkg::side_t               in_side,
  input  wire [aou_pkg::ROOT_W-1:0]    in_root,
  input  wire [aou_pkg::NUM_W-1:0]     in_num,
  output logic                         out_vld,
  output aou_pkg::side_t               out_side,
  output logic [aou_pkg::QUO_W:0]      out_quo
);
  import aou_pkg::*;

  // den stage
  logic              d0_vld_r;
  side_t             d0_side_r;
  logic [DEN_W-1:0]  d0_den_r;
  logic [NUM_W-1:0]  d0_num_r;

  logic              vld_r  [0:DIV_STEPS-1];
  side_t             side_r [0:DIV_STEPS-1];
  logic [DEN_W-1:0]  den_r  [0:DIV_STEPS-1];
  logic [NUM_W-1:0]  num_r  [0:DIV_STEPS-1];
  logic [DEN_W-1:0]  rem_r  [0:DIV_STEPS-1];
  logic [QUO_W-1:0]  quo_r  [0:DIV_STEPS-1];
  logic              ovf_r  [0:DIV_STEPS-1];

  // rounding stage
  logic              fin_vld_r;
  side_t             fin_side_r, fin_side_nxt;
  logic [QUO_W:0]    fin_quo_r, fin_quo_nxt;
  logic [DEN_W-1:0]  last_den, last_rem;
  logic [QUO_W:0]    quo_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_vld_r  <= 1'b0;
      fin_vld_r <= 1'b0;
    end else if (en) begin
      d0_vld_r  <= in_vld;
      fin_vld_r <= vld_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_side_r  <= in_side;
      d0_den_r   <= DEN_W'(in_root) + EPS_Q32;
      d0_num_r   <= in_num;
      fin_side_r <= fin_side_nxt;
      fin_quo_r  <= fin_quo_nxt;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic             v_in, ovf_in, ge;
    side_t            side_in;
    logic [DEN_W-1:0] den_in, rem_in;
    logic [NUM_W-1:0] num_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W:0]   cur;

    if (i == 0) begin : g_first
      assign v_in    = d0_vld_r;
      assign side_in = d0_side_r;
      assign den_in  = d0_den_r;
      assign num_in  = d0_num_r;
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign ovf_in  = 1'b0;
    end else begin : g_next
      assign v_in    = vld_r[i-1];
      assign side_in = side_r[i-1];
      assign den_in  = den_r[i-1];
      assign num_in  = num_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign ovf_in  = ovf_r[i-1];
    end

    assign cur = {rem_in, num_in[NUM_W-1]};
    assign ge  = (cur >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= side_in;
        den_r[i]  <= den_in;
        num_r[i]  <= {num_in[NUM_W-2:0], 1'b0};
        rem_r[i]  <= DEN_W'(ge ? (cur - {1'b0, den_in}) : cur);
        if (i < NUM_W - QUO_W) begin
          quo_r[i] <= quo_in;
          ovf_r[i] <= ovf_in | ge;
        end else begin
          quo_r[i] <= {quo_in[QUO_W-2:0], ge};
          ovf_r[i] <= ovf_in;
        end
      end
    end
  end

  always_comb begin
    last_den     = den_r[DIV_STEPS-1];
    last_rem     = rem_r[DIV_STEPS-1];
    quo_inc      = {1'b0, quo_r[DIV_STEPS-1]} + (QUO_W+1)'(1);
    fin_side_nxt = side_r[DIV_STEPS-1];
    if (ovf_r[DIV_STEPS-1]) begin
      fin_quo_nxt      = {1'b1, {QUO_W{1'b0}}};
      fin_side_nxt.sat = 1'b1;
    end else if ({last_rem, 1'b0} >= {1'b0, last_den}) begin
      fin_quo_nxt = quo_inc;
      if (quo_inc[QUO_W]) begin
        fin_side_nxt.sat = 1'b1;
      end
    end else begin
      fin_quo_nxt = {1'b0, quo_r[DIV_STEPS-1]};
    end
  end

  assign out_vld  = fin_vld_r;
  assign out_side = fin_side_r;
  assign out_quo  = fin_quo_r;

endmodule

`default_nettype wire

/* bench/adam_optimizer_update_unit_tb.sv */
// ---------------------------------------------------------------------------
// adam_optimizer_update_unit_tb
// Self-checking bench for the Adam update unit. Beats are driven in random
// bursts while the output side stalls on its own pattern. Each accepted beat
// runs through a bit-exact model of the Adam step, which keeps shadow
// weight and moment stores. Output beats are compared in order. A directed
// table is followed by random phases under several register settings,
// including the extremes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module adam_optimizer_update_unit_tb;
  import aou_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] grad;
    bit                 typed;
    logic signed [31:0] exp_w;
    bit                 exp_sat;
  } row_t;

  typedef struct {
    logic [SR_W-1:0]   rate;
    logic [CORR_W-1:0] corr1;
    logic [CORR_W-1:0] corr2;
  } setting_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  logic [SR_W-1:0]    rate_q = STEP_RATE_RST;
  logic [CORR_W-1:0]  corr1_q = FIRST_CORR_RST;
  logic [CORR_W-1:0]  corr2_q = SECOND_CORR_RST;
  logic signed [31:0] weight_shadow [int];
  logic signed [31:0] m_shadow [int];
  logic [V_W-1:0]     v_shadow [int];

  out_item_t pending_weights [$];
  bit        typed_flag [$];
  out_item_t typed_result [$];
  int        errors = 0;
  int        burst_left = 0;
  logic [IDX_W-1:0] hot_idx [32];

  adam_optimizer_update_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  function automatic logic [127:0] mul_round32(logic [127:0] x, logic [127:0] c);
    return (x * c + (128'd1 << 31)) >> 32;
  endfunction

  function automatic out_item_t adam_step(in_item_t it);
    out_item_t          res;
    int                 k;
    longint             g, m, w;
    logic signed [31:0] m_old, w_old;
    logic [127:0]       v_old, g2, vv, mabs, mhat, prod, root, cand, den, num, quo, rem;
    bit                 sat;
    k = int'(it.weight_index);
    sat = 1'b0;
    res.updated_index = it.weight_index;
    res.new_weight = '0;
    res.saturated = 1'b0;
    if (k >= NUM_WEIGHTS) return res;
    m_old = m_shadow.exists(k) ? m_shadow[k] : 32'sd0;
    w_old = weight_shadow.exists(k) ? weight_shadow[k] : 32'sd0;
    v_old = v_shadow.exists(k) ? 128'(v_shadow[k]) : 128'd0;
    g = longint'(it.gradient);

    m = (longint'(m_old) * longint'(B1_Q30) + g * longint'(C1_Q30) + (64'sd1 <<< 29)) >>> 30;
    if (m > 64'sd2147483647) begin m = 64'sd2147483647; sat = 1'b1; end
    if (m < -64'sd2147483648) begin m = -64'sd2147483648; sat = 1'b1; end

    g2 = 128'(g * g);
    vv = mul_round32(v_old << 4, 128'(B2_Q32)) + mul_round32(g2, 128'(C2_Q32));
    vv = (vv + 128'd8) >> 4;
    if (vv > 128'(V_MAX)) begin vv = 128'(V_MAX); sat = 1'b1; end

    mabs = (m < 0) ? 128'(-m) : 128'(m);
    mhat = (mabs * 128'(corr1_q) + (128'd1 << 19)) >> 20;

    prod = vv * 128'(corr2_q);
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= prod) root = cand;
    end
    den = root + 128'(EPS_Q32);

    num = (mhat * 128'(rate_q)) << 8;
    quo = num / den;
    rem = num % den;
    if (quo >= (128'd1 << 40)) begin
      quo = 128'd1 << 40;
      sat = 1'b1;
    end else begin
      if (2 * rem >= den) quo = quo + 1;
      if (quo >= (128'd1 << 40)) begin quo = 128'd1 << 40; sat = 1'b1; end
    end

    w = (m < 0) ? longint'(w_old) + longint'(quo[63:0]) : longint'(w_old) - longint'(quo[63:0]);
    if (w > 64'sd2147483647) begin w = 64'sd2147483647; sat = 1'b1; end
    if (w < -64'sd2147483648) begin w = -64'sd2147483648; sat = 1'b1; end

    m_shadow[k] = 32'(m);
    v_shadow[k] = vv[V_W-1:0];
    weight_shadow[k] = 32'(w);
    res.new_weight = 32'(w);
    res.saturated = sat;
    return res;
  endfunction

  // input side: predict on every accepted beat
  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && in_valid && !in_stall) begin
      exp_item = adam_step(in_data);
      if (typed_flag.size() != 0 && typed_flag.pop_front()) exp_item = typed_result.pop_front();
      pending_weights = {pending_weights, exp_item};
    end
  end

  // output side: compare against oldest expectation
  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_weights.size() == 0) begin
        $error("unexpected output beat, index %0d", out_data.updated_index);
        errors++;
      end else begin
        exp_item = pending_weights.pop_front();
        if (out_data.updated_index !== exp_item.updated_index) begin
          $error("updated_index: expected %0d, got %0d", exp_item.updated_index,
                 out_data.updated_index);
          errors++;
        end
        if (out_data.new_weight !== exp_item.new_weight) begin
          $error("new_weight: expected %0d, got %0d", exp_item.new_weight,
                 out_data.new_weight);
          errors++;
        end
        if (out_data.saturated !== exp_item.saturated) begin
          $error("saturated: expected %0b, got %0b", exp_item.saturated, out_data.saturated);
          errors++;
        end
      end
    end
  end

  // output stall pattern
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 300);
      out_stall <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 19) == 0) ? ~out_stall : out_stall;
        default: out_stall <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  task automatic send_beat(logic [IDX_W-1:0] idx, logic signed [31:0] grad);
    in_item_t beat;
    beat.weight_index = idx;
    beat.gradient = grad;
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 1) ? $urandom_range(1, 40) : 0;
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (TAG_DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_data <= val;
    case (r)
      CFG_STEP_RATE:   rate_q = val[SR_W-1:0];
      CFG_FIRST_CORR:  corr1_q = val;
      CFG_SECOND_CORR: corr2_q = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_grad();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return $signed(32'($urandom_range(0, 32'h01FF_FFFF))) - 32'sh0100_0000;
      8: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return 32'sd0;
    endcase
  endfunction

  row_t script [16] = '{
    '{17'd0,      32'sd0,           1'b1, 32'sd0, 1'b0},
    '{17'd131071, 32'sh7FFF_FFFF,   1'b0, 32'sd0, 1'b0},
    '{17'd1,      32'sh8000_0000,   1'b0, 32'sd0, 1'b0},
    '{17'd2,      32'sd1,           1'b0, 32'sd0, 1'b0},
    '{17'd3,      -32'sd1,          1'b0, 32'sd0, 1'b0},
    '{17'd131071, 32'sh7FFF_FFFF,   1'b0, 32'sd0, 1'b0},
    '{17'd131071, 32'sh7FFF_FFFF,   1'b0, 32'sd0, 1'b0},
    '{17'd131071, 32'sh7FFF_FFFF,   1'b0, 32'sd0, 1'b0},
    '{17'd1,      32'sh8000_0000,   1'b0, 32'sd0, 1'b0},
    '{17'd1,      32'sh8000_0000,   1'b0, 32'sd0, 1'b0},
    '{17'd4,      32'sh5555_5555,   1'b0, 32'sd0, 1'b0},
    '{17'd5,      32'shAAAA_AAAA,   1'b0, 32'sd0, 1'b0},
    '{17'd6,      32'sd0,           1'b1, 32'sd0, 1'b0},
    '{17'd65536,  32'sh0100_0000,   1'b0, 32'sd0, 1'b0},
    '{17'd65536,  -32'sh0100_0000,  1'b0, 32'sd0, 1'b0},
    '{17'd7,      32'sh0000_8000,   1'b0, 32'sd0, 1'b0}
  };

  setting_t settings [6] = '{
    '{24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{24'd0,       32'd0,         32'd0},
    '{24'hFF_FFFF, 32'd10485760,  32'd0},
    '{24'd3355,    32'd1048576,   32'd1048576},
    '{24'd100000,  32'd10485760,  32'd1048576000},
    '{24'd3355,    32'd10485760,  32'd1048576000}
  };

  initial begin
    out_item_t fixed;
    logic [IDX_W-1:0] idx;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      fixed.updated_index = script[i].idx;
      fixed.new_weight = script[i].exp_w;
      fixed.saturated = script[i].exp_sat;
      typed_flag = {typed_flag, script[i].typed};
      if (script[i].typed) typed_result = {typed_result, fixed};
      send_beat(script[i].idx, script[i].grad);
    end
    drain();

    foreach (settings[s]) begin
      if (s == 5) begin
        settings[s].rate = SR_W'($urandom_range(0, 24'hFF_FFFF));
        settings[s].corr1 = $urandom;
        settings[s].corr2 = $urandom;
      end
      write_reg(CFG_STEP_RATE, CFG_W'(settings[s].rate));
      write_reg(CFG_FIRST_CORR, settings[s].corr1);
      write_reg(CFG_SECOND_CORR, settings[s].corr2);
      foreach (hot_idx[h]) hot_idx[h] = IDX_W'($urandom_range(0, NUM_WEIGHTS - 1));
      for (int n = 0; n < 290; n++) begin
        idx = ($urandom_range(0, 9) < 6) ? hot_idx[$urandom_range(0, 31)]
                                          : IDX_W'($urandom_range(0, NUM_WEIGHTS - 1));
        typed_flag = {typed_flag, 1'b0};
        send_beat(idx, rand_grad());
        if (s == 3 && n == 150) drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
